// File: sv/usf_pkg.sv
// Shared types, constants and character classes for the URL span finder.
package usf_pkg;

    localparam int POS_W = 16;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam int OUT_W = 16;

    // Progress through the "://" separator
    typedef enum logic [1:0] {
        SEP_NONE   = 2'd0,
        SEP_COLON  = 2'd1,
        SEP_SLASH1 = 2'd2,
        SEP_SLASH2 = 2'd3
    } sep_t;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [OUT_W-1:0] url_start;
        logic [OUT_W-1:0] url_end;
        logic             overflow;
        logic             text_done;
    } result_t;

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_url_char(input logic [7:0] c);
        logic mark;
        unique case (c)
            8'h7E, 8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h3D, 8'h26, 8'h24, 8'h2D,
            8'h5F, 8'h2E, 8'h2B, 8'h21, 8'h2A, 8'h27, 8'h28, 8'h29, 8'h2C:
                mark = 1'b1;
            default:
                mark = 1'b0;
        endcase
        is_url_char = mark || is_letter(c) || ((c >= 8'h30) && (c <= 8'h39));
    endfunction

endpackage

// File: sv/usf_scan.sv
// Per-byte scanner state and span detection.
module usf_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  usf_pkg::item_t     item_q,
    output logic               hit,
    output usf_pkg::result_t   res
);

    logic [usf_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [usf_pkg::POS_W-1:0] run_start_reg, run_start_next;
    logic                      run_active_reg, run_active_next;
    logic [usf_pkg::POS_W-1:0] cand_start_reg, cand_start_next;
    logic                      cand_valid_reg, cand_valid_next;
    usf_pkg::sep_t             sep_reg, sep_next;
    logic                      in_url_reg, in_url_next;
    logic                      ovf_reg, ovf_next;

    always_comb
    begin
        logic [usf_pkg::POS_W-1:0] p;
        logic [usf_pkg::POS_W-1:0] nxt;
        logic [usf_pkg::POS_W-1:0] end_pos;
        logic                      sat;
        logic                      url;
        logic                      fresh;
        logic                      done;

        p     = pos_reg;
        sat   = (p == usf_pkg::POS_MAX);
        nxt   = sat ? p : p + 1'b1;
        url   = usf_pkg::is_url_char(item_q.ch);
        fresh = 1'b1;
        hit   = 1'b0;
        done  = 1'b0;
        end_pos = p;

        run_start_next  = run_start_reg;
        run_active_next = run_active_reg;
        cand_start_next = cand_start_reg;
        cand_valid_next = cand_valid_reg;
        sep_next        = sep_reg;
        in_url_next     = in_url_reg;
        ovf_next        = ovf_reg | sat;

        if (in_url_reg)
        begin
            fresh = 1'b0;
            if (!url)
            begin
                hit             = 1'b1;
                end_pos         = p;
                done            = item_q.last;
                in_url_next     = 1'b0;
                run_active_next = 1'b0;
            end
        end
        else if (cand_valid_reg)
        begin
            priority if (sep_reg == usf_pkg::SEP_COLON && item_q.ch == usf_pkg::CH_SLASH)
            begin
                sep_next = usf_pkg::SEP_SLASH1;
                fresh    = 1'b0;
            end
            else if (sep_reg == usf_pkg::SEP_SLASH1 && item_q.ch == usf_pkg::CH_SLASH)
            begin
                sep_next = usf_pkg::SEP_SLASH2;
                fresh    = 1'b0;
            end
            else if (sep_reg == usf_pkg::SEP_SLASH2 && url)
            begin
                in_url_next     = 1'b1;
                cand_valid_next = 1'b0;
                sep_next        = usf_pkg::SEP_NONE;
                fresh           = 1'b0;
            end
            else
            begin
                cand_valid_next = 1'b0;
                sep_next        = usf_pkg::SEP_NONE;
            end
        end

        if (fresh)
        begin
            priority if (usf_pkg::is_letter(item_q.ch))
            begin
                if (!run_active_reg)
                begin
                    run_start_next  = p;
                    run_active_next = 1'b1;
                end
            end
            else if (item_q.ch == usf_pkg::CH_COLON && run_active_reg)
            begin
                cand_start_next = run_start_reg;
                cand_valid_next = 1'b1;
                sep_next        = usf_pkg::SEP_COLON;
                run_active_next = 1'b0;
            end
            else
            begin
                run_active_next = 1'b0;
            end
        end

        // span still open on the final byte closes one past it
        if (item_q.last && in_url_next && !hit)
        begin
            hit     = 1'b1;
            end_pos = nxt;
            done    = 1'b1;
        end

        res.url_start = usf_pkg::OUT_W'(cand_start_reg);
        res.url_end   = usf_pkg::OUT_W'(end_pos);
        res.overflow  = ovf_next;
        res.text_done = done;

        if (item_q.last)
        begin
            pos_next        = '0;
            run_start_next  = '0;
            run_active_next = 1'b0;
            cand_start_next = '0;
            cand_valid_next = 1'b0;
            sep_next        = usf_pkg::SEP_NONE;
            in_url_next     = 1'b0;
            ovf_next        = 1'b0;
        end
        else
        begin
            pos_next = nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            run_start_reg  <= '0;
            run_active_reg <= 1'b0;
            cand_start_reg <= '0;
            cand_valid_reg <= 1'b0;
            sep_reg        <= usf_pkg::SEP_NONE;
            in_url_reg     <= 1'b0;
            ovf_reg        <= 1'b0;
        end
        else if (step)
        begin
            pos_reg        <= pos_next;
            run_start_reg  <= run_start_next;
            run_active_reg <= run_active_next;
            cand_start_reg <= cand_start_next;
            cand_valid_reg <= cand_valid_next;
            sep_reg        <= sep_next;
            in_url_reg     <= in_url_next;
            ovf_reg        <= ovf_next;
        end
    end

endmodule

// File: sv/url_span_finder.sv
// Top level: input register, scanner and result register.
// URL span finder. Text bytes enter on the item channel, one per transfer, with last set
// on the final byte of each text; every URL-like span (letters, "://", then URL characters)
// comes out as one result with its start and end offsets, the sticky overflow flag and
// text_done. The block takes one byte per clock unless a waiting result stalls it: a byte is
// registered, scanned by a single level of compare-and-update logic and its result, if any,
// lands in the result register when the byte advances. A waiting result stalls the input only
// once both the input and result registers are full. Offsets are 16 bits and saturate at 65535.
module url_span_finder (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  usf_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output usf_pkg::result_t result
);

    logic             full_reg;
    usf_pkg::item_t   item_reg;
    logic             advance;
    logic             hit;
    usf_pkg::result_t res;
    usf_pkg::result_t result_reg;
    logic             result_valid_reg;

    assign advance    = full_reg && (!result_valid_reg || result_ready);
    assign item_ready = !full_reg || advance;

    usf_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item_q (item_reg),
        .hit    (hit),
        .res    (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            full_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= hit;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && hit)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.url_start <= result.url_end))
        else $error("span end before start");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !full_reg |-> item_ready)
        else $error("input stalled while empty");

    a_hit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && hit) |=> result_valid)
        else $error("span result lost");
`endif

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// Testbench for url_span_finder: directed byte table, random texts, span prediction.
module tb;

    localparam int LATENCY = 8;
    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int N_ROWS = 26;
    localparam logic [8*19-1:0] MARKS = "~;/?:@=&$-_.+!*'(),";
    localparam usf_pkg::result_t NO_SPAN = '0;

    typedef struct packed {
        logic [7:0]       ch;
        logic             last;
        logic [16:0]      reps;
        logic             typed;
        usf_pkg::result_t span;
    } row_t;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             item_valid;
    logic             item_ready;
    usf_pkg::item_t   item;
    logic             result_valid;
    logic             result_ready;
    usf_pkg::result_t result;

    usf_pkg::result_t span_q[$];
    int      errors = 0;
    int      results_seen = 0;
    int      quiet = 0;
    logic    no_gaps = 1'b0;

    // scanner state for prediction
    logic [usf_pkg::POS_W-1:0] at_pos = '0;
    logic [usf_pkg::POS_W-1:0] run_start = '0;
    logic [usf_pkg::POS_W-1:0] cand_start = '0;
    logic                      run_open = 1'b0;
    logic                      cand_open = 1'b0;
    logic                      in_url = 1'b0;
    logic                      ovf_seen = 1'b0;
    usf_pkg::sep_t             sep_stage = usf_pkg::SEP_NONE;

    row_t dir_rows [N_ROWS] = '{
        // span closed by a non-URL final byte
        '{"h",   1'b0, 17'd1, 1'b0, NO_SPAN},
        '{":",   1'b0, 17'd1, 1'b0, NO_SPAN},
        '{"/",   1'b0, 17'd1, 1'b0, NO_SPAN},
        '{"/",   1'b0, 17'd1, 1'b0, NO_SPAN},
        '{"x",   1'b0, 17'd1, 1'b0, NO_SPAN},
        '{8'h00, 1'b1, 17'd1, 1'b1, '{16'd0, 16'd5, 1'b0, 1'b1}},
        // separator after a digit starts nothing
        '{"9",   1'b0, 17'd1, 1'b0, NO_SPAN},
        '{":",   1'b0, 17'd1, 1'b0, NO_SPAN},
        '{"/",   1'b0, 17'd1, 1'b0, NO_SPAN},
        '{"/",   1'b0, 17'd1, 1'b0, NO_SPAN},
        '{"q",   1'b1, 17'd1, 1'b0, NO_SPAN},
        // separator broken partway, then a span running to the end
        '{8'hFF, 1'b0, 17'd1, 1'b0, NO_SPAN},
        '{"A",   1'b0, 17'd1, 1'b0, NO_SPAN},
        '{":",   1'b0, 17'd1, 1'b0, NO_SPAN},
        '{"/",   1'b0, 17'd1, 1'b0, NO_SPAN},
        '{8'hFF, 1'b0, 17'd1, 1'b0, NO_SPAN},
        '{"b",   1'b0, 17'd1, 1'b0, NO_SPAN},
        '{":",   1'b0, 17'd1, 1'b0, NO_SPAN},
        '{"/",   1'b0, 17'd1, 1'b0, NO_SPAN},
        '{"/",   1'b0, 17'd1, 1'b0, NO_SPAN},
        '{")",   1'b1, 17'd1, 1'b1, '{16'd5, 16'd10, 1'b0, 1'b1}},
        // full separator followed by a non-URL byte
        '{"a",   1'b0, 17'd1, 1'b0, NO_SPAN},
        '{":",   1'b0, 17'd1, 1'b0, NO_SPAN},
        '{"/",   1'b0, 17'd1, 1'b0, NO_SPAN},
        '{"/",   1'b0, 17'd1, 1'b0, NO_SPAN},
        '{" ",   1'b1, 17'd1, 1'b0, NO_SPAN}
    };

    url_span_finder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_url_byte(input logic [7:0] c);
        if (is_alpha(c) || (c >= "0" && c <= "9"))
            return 1'b1;
        for (int k = 0; k < 19; k++)
            if (c == MARKS[8*k +: 8])
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [7:0] rand_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? "a" : "A";
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_url_byte();
        case ($urandom_range(0, 2))
            0: return rand_letter();
            1: return "0" + 8'($urandom_range(0, 9));
            default: return MARKS[8*$urandom_range(0, 18) +: 8];
        endcase
    endfunction

    function automatic logic [7:0] rand_other_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_url_byte(c));
        return c;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // one byte through the scanner; span is valid when found is set
    task automatic predict_span(input usf_pkg::item_t it, output logic found,
                                output usf_pkg::result_t span);
        logic [usf_pkg::POS_W-1:0] nxt;
        logic                      url;
        logic                      fresh;
        url = is_url_byte(it.ch);
        fresh = 1'b1;
        found = 1'b0;
        span = NO_SPAN;
        if (at_pos == usf_pkg::POS_MAX)
        begin
            nxt = usf_pkg::POS_MAX;
            ovf_seen = 1'b1;
        end
        else
            nxt = at_pos + 1'b1;

        if (in_url)
        begin
            fresh = 1'b0;
            if (!url)
            begin
                span.url_start = cand_start;
                span.url_end = at_pos;
                span.overflow = ovf_seen;
                span.text_done = it.last;
                found = 1'b1;
                in_url = 1'b0;
                run_open = 1'b0;
            end
        end
        else if (cand_open)
        begin
            if (sep_stage == usf_pkg::SEP_COLON && it.ch == usf_pkg::CH_SLASH)
            begin
                sep_stage = usf_pkg::SEP_SLASH1;
                fresh = 1'b0;
            end
            else if (sep_stage == usf_pkg::SEP_SLASH1 && it.ch == usf_pkg::CH_SLASH)
            begin
                sep_stage = usf_pkg::SEP_SLASH2;
                fresh = 1'b0;
            end
            else if (sep_stage == usf_pkg::SEP_SLASH2 && url)
            begin
                in_url = 1'b1;
                cand_open = 1'b0;
                sep_stage = usf_pkg::SEP_NONE;
                fresh = 1'b0;
            end
            else
            begin
                cand_open = 1'b0;
                sep_stage = usf_pkg::SEP_NONE;
            end
        end

        if (fresh)
        begin
            if (is_alpha(it.ch))
            begin
                if (!run_open)
                begin
                    run_start = at_pos;
                    run_open = 1'b1;
                end
            end
            else if (it.ch == usf_pkg::CH_COLON && run_open)
            begin
                cand_start = run_start;
                cand_open = 1'b1;
                sep_stage = usf_pkg::SEP_COLON;
                run_open = 1'b0;
            end
            else
                run_open = 1'b0;
        end

        // span still open on the final byte
        if (it.last && in_url && !found)
        begin
            span.url_start = cand_start;
            span.url_end = nxt;
            span.overflow = ovf_seen;
            span.text_done = 1'b1;
            found = 1'b1;
        end

        if (it.last)
        begin
            at_pos = '0;
            run_start = '0;
            run_open = 1'b0;
            cand_start = '0;
            cand_open = 1'b0;
            sep_stage = usf_pkg::SEP_NONE;
            in_url = 1'b0;
            ovf_seen = 1'b0;
        end
        else
            at_pos = nxt;
    endtask

    task automatic send_byte(input usf_pkg::item_t it, input logic typed,
                             input usf_pkg::result_t typed_span);
        int               gap;
        logic             found;
        usf_pkg::result_t span;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (!item_ready);
        predict_span(it, found, span);
        if (typed)
            span_q = {span_q, typed_span};
        else if (found)
            span_q = {span_q, span};
    endtask

    // sender stops until every pending span has come out
    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (span_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    initial
    begin
        usf_pkg::item_t one;
        logic [7:0]     text[$];
        int             sent;
        int             kind;
        logic           paused;

        item_valid = 1'b0;
        item = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            no_gaps = (dir_rows[i].reps > 1);
            one.ch = dir_rows[i].ch;
            one.last = dir_rows[i].last;
            for (int k = 0; k < dir_rows[i].reps; k++)
                send_byte(one, dir_rows[i].typed && (k == dir_rows[i].reps - 1),
                          dir_rows[i].span);
        end
        no_gaps = 1'b0;
        drain();

        sent = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            text = {};
            no_gaps = ($urandom_range(0, 5) == 0);
            repeat ($urandom_range(1, 4))
            begin
                kind = $urandom_range(0, 99);
                if (kind < 55)
                begin
                    // well-formed span, usually closed by a stray byte
                    if ($urandom_range(0, 3) == 0)
                        text = {text, rand_url_byte()};
                    repeat ($urandom_range(1, 5)) text = {text, rand_letter()};
                    text = {text, usf_pkg::CH_COLON};
                    text = {text, usf_pkg::CH_SLASH};
                    text = {text, usf_pkg::CH_SLASH};
                    repeat ($urandom_range(1, 12)) text = {text, rand_url_byte()};
                    if ($urandom_range(0, 9) < 7)
                        text = {text, rand_other_byte()};
                end
                else if (kind < 70)
                begin
                    // separator cut to zero, one or two slashes, then any byte
                    repeat ($urandom_range(1, 3)) text = {text, rand_letter()};
                    text = {text, usf_pkg::CH_COLON};
                    repeat ($urandom_range(0, 2)) text = {text, usf_pkg::CH_SLASH};
                    text = {text, 8'($urandom_range(0, 255))};
                end
                else if (kind < 80)
                begin
                    // separator with no letter in front
                    text = {text, 8'($urandom_range(0, 1) ? rand_other_byte()
                                     : "0" + 8'($urandom_range(0, 9)))};
                    text = {text, usf_pkg::CH_COLON};
                    text = {text, usf_pkg::CH_SLASH};
                    text = {text, usf_pkg::CH_SLASH};
                    repeat ($urandom_range(1, 4)) text = {text, rand_url_byte()};
                end
                else
                    repeat ($urandom_range(1, 6)) text = {text, 8'($urandom_range(0, 255))};
            end
            foreach (text[k])
            begin
                one.ch = text[k];
                one.last = (k == text.size() - 1);
                send_byte(one, 1'b0, NO_SPAN);
            end
            sent += text.size();
            if (!paused && sent >= RANDOM_ITEMS / 2)
            begin
                paused = 1'b1;
                drain();
            end
        end
        no_gaps = 1'b0;
        drain();

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int   stall;
        logic held;
        stall = 0;
        held = 1'b0;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            // one long hold so the block backs up and stalls its input
            if (!held && results_seen >= 30)
            begin
                held = 1'b1;
                stall = 300;
            end
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                stall--;
            end
            else
            begin
                result_ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        usf_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (span_q.size() == 0)
            begin
                $error("result transfer with nothing pending: %p", result);
                errors++;
            end
            else
            begin
                want = span_q.pop_front();
                if (result.url_start !== want.url_start)
                begin
                    $error("url_start: expected %0d, got %0d", want.url_start, result.url_start);
                    errors++;
                end
                if (result.url_end !== want.url_end)
                begin
                    $error("url_end: expected %0d, got %0d", want.url_end, result.url_end);
                    errors++;
                end
                if (result.overflow !== want.overflow)
                begin
                    $error("overflow: expected %0b, got %0b", want.overflow, result.overflow);
                    errors++;
                end
                if (result.text_done !== want.text_done)
                begin
                    $error("text_done: expected %0b, got %0b", want.text_done, result.text_done);
                    errors++;
                end
            end
        end
    end

    // watchdog: too long without any transfer on either side
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule

// File: files.f
sv/usf_pkg.sv
sv/usf_scan.sv
sv/url_span_finder.sv
sim/tb.sv
